// ===== hdl/opd_pkg.sv =====
`timescale 1ns / 1ps

package opd_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
    localparam int HDR_SHIFT_W  = (HEADER_BYTES - 1) * 8;
    localparam int LEN_W        = 12;
    localparam int OFS_W        = 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_ABORT = 2'd2;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_SYNC = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] packet_length;
        logic [OFS_W-1:0] whitener_offset;
        logic             last;
        logic [1:0]       status;
    } t_result;

    typedef enum logic {
        CMD_DATA,
        CMD_SYNC
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_SEARCH,
        MODE_HEADER,
        MODE_PAYLOAD
    } t_mode;

endpackage

// ===== hdl/opd_front.sv =====
`timescale 1ns / 1ps

module opd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  opd_pkg::t_item i_item,
    input  logic          push,
    output logic          full,
    output opd_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_take
);
    import opd_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    t_cmd              n_cmd;
    logic              w_wr;
    logic              w_rd;

    always_comb begin
        n_cmd.op   = (i_item.kind == KIND_SYNC) ? CMD_SYNC : CMD_DATA;
        n_cmd.data = i_item.data_byte;
    end

    assign full        = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign w_wr        = push && !full;
    assign w_rd        = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/opd_back.sv =====
`timescale 1ns / 1ps

module opd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  opd_pkg::t_cmd    i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_cmd_take,
    output opd_pkg::t_result o_result,
    output logic             empty,
    input  logic             pop
);
    import opd_pkg::*;

    t_mode                  r_mode;
    t_mode                  n_mode;
    logic [HDR_SHIFT_W-1:0] r_shift;
    logic [HDR_SHIFT_W-1:0] n_shift;
    logic [HDR_CNT_W-1:0]   r_hdr_cnt;
    logic [HDR_CNT_W-1:0]   n_hdr_cnt;
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       n_len;
    logic [OFS_W-1:0]       r_ofs;
    logic [OFS_W-1:0]       n_ofs;
    logic [LEN_W-1:0]       r_pay_cnt;
    logic [LEN_W-1:0]       n_pay_cnt;
    t_result                r_out;
    t_result                n_out;
    logic                   r_out_valid;
    logic                   n_load;

    logic [31:0]      w_header;
    logic             w_hdr_done;
    logic             w_hdr_ok;
    logic [LEN_W-1:0] w_hdr_len;
    logic [LEN_W-1:0] w_cnt_inc;
    logic             w_sync;

    assign o_cmd_take = i_cmd_valid && (!r_out_valid || pop);
    assign w_sync     = (i_cmd.op == CMD_SYNC);
    assign w_header   = {r_shift, i_cmd.data};
    assign w_hdr_done = (r_hdr_cnt == HDR_CNT_W'(HEADER_BYTES - 1));
    assign w_hdr_ok   = (w_header[31:16] == w_header[15:0]);
    assign w_hdr_len  = w_header[16 +: LEN_W];
    assign w_cnt_inc  = r_pay_cnt + 1'b1;

    // next mode
    always_comb begin
        n_mode = r_mode;
        if (o_cmd_take) begin
            unique case (r_mode)
                MODE_HEADER: begin
                    if (w_sync) begin
                        n_mode = MODE_HEADER;
                    end else if (w_hdr_done) begin
                        if (!w_hdr_ok || w_hdr_len == '0) begin
                            n_mode = MODE_SEARCH;
                        end else begin
                            n_mode = MODE_PAYLOAD;
                        end
                    end
                end
                MODE_PAYLOAD: begin
                    if (w_sync) begin
                        n_mode = MODE_HEADER;
                    end else if (w_cnt_inc == r_len) begin
                        n_mode = MODE_SEARCH;
                    end
                end
                default: begin
                    n_mode = w_sync ? MODE_HEADER : MODE_SEARCH;
                end
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_shift   = r_shift;
        n_hdr_cnt = r_hdr_cnt;
        n_len     = r_len;
        n_ofs     = r_ofs;
        n_pay_cnt = r_pay_cnt;
        n_load    = 1'b0;
        n_out     = '0;
        if (o_cmd_take) begin
            unique case (r_mode)
                MODE_HEADER: begin
                    if (w_sync) begin
                        n_shift   = '0;
                        n_hdr_cnt = '0;
                    end else begin
                        n_shift   = w_header[HDR_SHIFT_W-1:0];
                        n_hdr_cnt = r_hdr_cnt + 1'b1;
                        if (w_hdr_done && w_hdr_ok) begin
                            n_len     = w_hdr_len;
                            n_ofs     = w_header[31 -: OFS_W];
                            n_pay_cnt = '0;
                            if (w_hdr_len == '0) begin
                                n_load                = 1'b1;
                                n_out.packet_length   = '0;
                                n_out.whitener_offset = w_header[31 -: OFS_W];
                                n_out.last            = 1'b1;
                                n_out.status          = ST_EMPTY;
                            end
                        end
                    end
                end
                MODE_PAYLOAD: begin
                    n_load                = 1'b1;
                    n_out.packet_length   = r_len;
                    n_out.whitener_offset = r_ofs;
                    if (w_sync) begin
                        n_out.status = ST_ABORT;
                        n_shift      = '0;
                        n_hdr_cnt    = '0;
                    end else begin
                        n_pay_cnt          = w_cnt_inc;
                        n_out.payload_byte = i_cmd.data;
                        n_out.last         = (w_cnt_inc == r_len);
                        n_out.status       = ST_BYTE;
                    end
                end
                default: begin
                    if (w_sync) begin
                        n_shift   = '0;
                        n_hdr_cnt = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SEARCH;
            r_shift     <= '0;
            r_hdr_cnt   <= '0;
            r_len       <= '0;
            r_ofs       <= '0;
            r_pay_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_shift   <= n_shift;
            r_hdr_cnt <= n_hdr_cnt;
            r_len     <= n_len;
            r_ofs     <= n_ofs;
            r_pay_cnt <= n_pay_cnt;
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;
    assign empty    = !r_out_valid;

    a_abort_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_take && w_sync && r_mode == MODE_PAYLOAD)
            |=> (r_mode == MODE_HEADER && r_hdr_cnt == '0 && r_shift == '0))
        else $error("abort did not restart header collection");

    a_last_to_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_load && n_out.last) |=> (r_mode == MODE_SEARCH))
        else $error("final result without return to search");

    a_count_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_PAYLOAD) |-> (r_pay_cnt < r_len))
        else $error("payload count reached length while streaming");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !pop) |-> !n_load)
        else $error("waiting result overwritten");

endmodule

// ===== hdl/ofdm_packet_deframer.sv =====
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+------------------------------
// input    | push / full          | i_item   (kind, data_byte)
// result   | empty / pop          | o_result (byte, len, ofs, last, status)
//
// One request is taken per cycle while the queue is not full; the header FSM in the
// back end consumes one queued request per cycle whenever the result register is
// free or being popped. Requests pass the four-entry queue, then the result register.
// Reset is synchronous: queue emptied, mode back to search, result register empty.
// Either side may stall; the queue absorbs up to four requests behind a held result.

module ofdm_packet_deframer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  opd_pkg::t_item   i_item,
    input  logic             push,
    output logic             full,
    output opd_pkg::t_result o_result,
    output logic             empty,
    input  logic             pop
);
    import opd_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_take;

    opd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .push        (push),
        .full        (full),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_take  (w_cmd_take)
    );

    opd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_take  (w_cmd_take),
        .o_result    (o_result),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
